FILE: rtl/lspc_pkg.sv
// Shared types and constants of the linear sieve prime counter.
// Used by lspc_ctrl, lspc_datapath and the top level; depends on nothing.
`default_nettype none

package lspc_pkg;

    localparam int LIMIT_W  = 17;
    localparam int COUNT_W  = 16;
    localparam int FOUND_W  = 15;
    localparam int STATUS_W = 2;
    localparam int PROD_W   = 2 * LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd100000;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNBUILT = 2'd2;

    // Micro-operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR,
        OP_SV_INIT,
        OP_SV_RD,
        OP_SV_CHK,
        OP_IN_RD,
        OP_IN_MUL,
        OP_IN_CHK,
        OP_NEXT_I,
        OP_CNT_INIT,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_BUILD_END,
        OP_Q_CHK,
        OP_Q_LO,
        OP_Q_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic lim_lt2;
        logic i_at_lim;
        logic j_at_listed;
        logic inner_stop;
        logic query_ok;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/lspc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the count table and the prime list.
`default_nettype none

module lspc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/lspc_datapath.sv
// Datapath of the prime counter: limit register, counters, multiplier and
// the two RAMs. Depends on lspc_pkg and lspc_ram; driven by lspc_ctrl.
`default_nettype none

module lspc_datapath
    import lspc_pkg::*;
#(
    parameter int TABLE_SIZE       = 131072,
    parameter int PRIME_LIST_DEPTH = 16384
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]  cfg_wr_data,
    input  wire logic [LIMIT_W-1:0]  s_low,
    input  wire logic [LIMIT_W-1:0]  s_high,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    output logic      [COUNT_W-1:0]  m_count,
    output logic      [STATUS_W-1:0] m_status
);

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int PIW = $clog2(PRIME_LIST_DEPTH);
    localparam int PLW = $clog2(PRIME_LIST_DEPTH + 1);

    logic [LIMIT_W-1:0]  limit_reg;
    logic                built_reg;
    logic [LIMIT_W-1:0]  lo_reg, hi_reg;
    logic [LIMIT_W-1:0]  i_reg, i_next;
    logic [PLW-1:0]      j_reg, j_next;
    logic [PLW-1:0]      listed_reg, listed_next;
    logic [FOUND_W-1:0]  total_reg, total_next;
    logic [LIMIT_W-1:0]  fi_reg;
    logic [LIMIT_W-1:0]  p_reg;
    logic [PROD_W-1:0]   m_reg;
    logic [LIMIT_W-1:0]  run_reg, run_next;
    logic [LIMIT_W-1:0]  upper_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [LIMIT_W-1:0]  lim_eff;
    logic                list_full;
    logic                bound_bad;
    logic [LIMIT_W-1:0]  diff;
    logic [LIMIT_W-1:0]  lower;

    logic                tbl_we;
    logic [AW-1:0]       tbl_waddr, tbl_raddr;
    logic [LIMIT_W-1:0]  tbl_wdata, tbl_rdata;
    logic                pl_we;
    logic [LIMIT_W-1:0]  pl_rdata;

    // The limit is clamped to the last table entry.
    assign lim_eff = (32'(limit_reg) > 32'(TABLE_SIZE - 1)) ? LIMIT_W'(TABLE_SIZE - 1)
                                                            : limit_reg;
    assign list_full = (listed_reg == PLW'(PRIME_LIST_DEPTH));
    assign bound_bad = (lo_reg > lim_eff) || (hi_reg > lim_eff);

    assign stat.lim_lt2     = (lim_eff < LIMIT_W'(2));
    assign stat.i_at_lim    = (i_reg == lim_eff);
    assign stat.j_at_listed = (j_reg == listed_reg);
    assign stat.inner_stop  = (p_reg > fi_reg) || (m_reg > PROD_W'(lim_eff));
    assign stat.query_ok    = built_reg && !bound_bad;

    assign lower = (lo_reg == '0) ? '0 : tbl_rdata;
    assign diff  = upper_reg - lower;

    // Running count for the conversion sweep: a prime is its own factor.
    always_comb begin
        run_next = run_reg;
        if ((i_reg >= LIMIT_W'(2)) && (tbl_rdata == i_reg)) begin
            run_next = run_reg + LIMIT_W'(1);
        end
    end

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = AW'(i_reg);
        tbl_wdata = '0;
        tbl_raddr = AW'(i_reg);
        pl_we     = 1'b0;
        case (cmd.op)
            OP_CLR: begin
                tbl_we = 1'b1;
            end
            OP_SV_CHK: begin
                if (tbl_rdata == '0) begin
                    tbl_we    = 1'b1;
                    tbl_wdata = i_reg;
                    pl_we     = !list_full;
                end
            end
            OP_IN_CHK: begin
                if (!stat.inner_stop) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = AW'(m_reg);
                    tbl_wdata = p_reg;
                end
            end
            OP_CNT_WR: begin
                tbl_we    = 1'b1;
                tbl_wdata = run_next;
            end
            OP_Q_CHK: begin
                tbl_raddr = AW'(hi_reg);
            end
            OP_Q_LO: begin
                tbl_raddr = AW'(lo_reg - LIMIT_W'(1));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        i_next      = i_reg;
        j_next      = j_reg;
        listed_next = listed_reg;
        total_next  = total_reg;
        case (cmd.op)
            OP_LOAD:     i_next = '0;
            OP_CLR:      i_next = i_reg + LIMIT_W'(1);
            OP_SV_INIT: begin
                i_next      = LIMIT_W'(2);
                listed_next = '0;
                total_next  = '0;
            end
            OP_SV_CHK: begin
                j_next = '0;
                if (tbl_rdata == '0) begin
                    total_next = total_reg + FOUND_W'(1);
                    if (!list_full) begin
                        listed_next = listed_reg + PLW'(1);
                    end
                end
            end
            OP_IN_CHK:   j_next = j_reg + PLW'(1);
            OP_NEXT_I:   i_next = i_reg + LIMIT_W'(1);
            OP_CNT_INIT: i_next = '0;
            OP_CNT_WR:   i_next = i_reg + LIMIT_W'(1);
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= LIMIT_RESET;
            built_reg  <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            listed_reg <= '0;
            total_reg  <= '0;
        end else begin
            i_reg      <= i_next;
            j_reg      <= j_next;
            listed_reg <= listed_next;
            total_reg  <= total_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
                built_reg <= 1'b0;
            end else if (cmd.op == OP_BUILD_END) begin
                built_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            lo_reg <= s_low;
            hi_reg <= s_high;
        end
        if (cmd.op == OP_SV_CHK) begin
            fi_reg <= (tbl_rdata == '0) ? i_reg : tbl_rdata;
        end
        if (cmd.op == OP_IN_MUL) begin
            p_reg <= pl_rdata;
            m_reg <= PROD_W'(i_reg) * PROD_W'(pl_rdata);
        end
        if (cmd.op == OP_CNT_INIT) begin
            run_reg <= '0;
        end else if (cmd.op == OP_CNT_WR) begin
            run_reg <= run_next;
        end
        if (cmd.op == OP_Q_LO) begin
            upper_reg <= tbl_rdata;
        end
        case (cmd.op)
            OP_BUILD_END: begin
                res_count_reg  <= COUNT_W'(total_reg);
                res_status_reg <= STAT_OK;
            end
            OP_Q_CHK: begin
                res_count_reg  <= '0;
                res_status_reg <= built_reg ? STAT_RANGE : STAT_UNBUILT;
            end
            OP_Q_END: begin
                res_count_reg  <= diff[COUNT_W-1:0];
                res_status_reg <= STAT_OK;
            end
            default: begin
            end
        endcase
        if (cmd.out_load) begin
            out_count_reg  <= res_count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_count  = out_count_reg;
    assign m_status = out_status_reg;

    lspc_ram #(
        .WIDTH(LIMIT_W),
        .DEPTH(TABLE_SIZE)
    ) u_table (
        .aclk (aclk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    lspc_ram #(
        .WIDTH(LIMIT_W),
        .DEPTH(PRIME_LIST_DEPTH)
    ) u_primes (
        .aclk (aclk),
        .we   (pl_we),
        .waddr(listed_reg[PIW-1:0]),
        .wdata(i_reg),
        .raddr(j_reg[PIW-1:0]),
        .rdata(pl_rdata)
    );

    a_listed_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        listed_reg <= PLW'(PRIME_LIST_DEPTH))
        else $error("prime list fill count beyond its depth");

    a_inner_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_IN_MUL) |-> (j_reg < listed_reg))
        else $error("prime list read beyond the listed primes");

    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_CLR || cmd.op == OP_SV_RD || cmd.op == OP_CNT_WR)
        |-> (i_reg <= lim_eff))
        else $error("table sweep index beyond the limit");

endmodule

`default_nettype wire

FILE: rtl/lspc_ctrl.sv
// Controller of the prime counter: sequences build and query operations and
// owns the request handshakes. Depends on lspc_pkg; drives lspc_datapath.
`default_nettype none

module lspc_ctrl
    import lspc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  s_mode,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_SV_INIT,
        ST_SV_RD,
        ST_SV_CHK,
        ST_IN_RD,
        ST_IN_MUL,
        ST_IN_CHK,
        ST_NEXT_I,
        ST_CNT_INIT,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_BUILD_END,
        ST_Q_CHK,
        ST_Q_LO,
        ST_Q_END,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NOP;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op     = OP_LOAD;
                    state_next = s_mode ? ST_Q_CHK : ST_CLR;
                end
            end
            ST_CLR: begin
                cmd.op     = OP_CLR;
                state_next = stat.i_at_lim ? ST_SV_INIT : ST_CLR;
            end
            ST_SV_INIT: begin
                cmd.op     = OP_SV_INIT;
                state_next = stat.lim_lt2 ? ST_CNT_INIT : ST_SV_RD;
            end
            ST_SV_RD: begin
                cmd.op     = OP_SV_RD;
                state_next = ST_SV_CHK;
            end
            ST_SV_CHK: begin
                cmd.op     = OP_SV_CHK;
                state_next = ST_IN_RD;
            end
            ST_IN_RD: begin
                cmd.op     = OP_IN_RD;
                state_next = stat.j_at_listed ? ST_NEXT_I : ST_IN_MUL;
            end
            ST_IN_MUL: begin
                cmd.op     = OP_IN_MUL;
                state_next = ST_IN_CHK;
            end
            ST_IN_CHK: begin
                cmd.op     = OP_IN_CHK;
                state_next = stat.inner_stop ? ST_NEXT_I : ST_IN_RD;
            end
            ST_NEXT_I: begin
                cmd.op     = OP_NEXT_I;
                state_next = stat.i_at_lim ? ST_CNT_INIT : ST_SV_RD;
            end
            ST_CNT_INIT: begin
                cmd.op     = OP_CNT_INIT;
                state_next = ST_CNT_RD;
            end
            ST_CNT_RD: begin
                cmd.op     = OP_CNT_RD;
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                cmd.op     = OP_CNT_WR;
                state_next = stat.i_at_lim ? ST_BUILD_END : ST_CNT_RD;
            end
            ST_BUILD_END: begin
                cmd.op     = OP_BUILD_END;
                state_next = ST_DONE;
            end
            ST_Q_CHK: begin
                cmd.op     = OP_Q_CHK;
                state_next = stat.query_ok ? ST_Q_LO : ST_DONE;
            end
            ST_Q_LO: begin
                cmd.op     = OP_Q_LO;
                state_next = ST_Q_END;
            end
            ST_Q_END: begin
                cmd.op     = OP_Q_END;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while its request is pending");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second request taken while one is still at work");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");

endmodule

`default_nettype wire

FILE: rtl/linear_sieve_prime_counter.sv
// Top level of the linear sieve prime counter.
// Depends on lspc_pkg, lspc_ctrl, lspc_datapath and lspc_ram.
`default_nettype none

// A build request (mode 0) sieves 2..L, L being sieve_limit clamped to
// TABLE_SIZE-1, and answers with the number of primes found; a query request
// (mode 1) answers with the number of primes in [low_bound, high_bound],
// status 1 if a bound exceeds L and status 2 if no build has run since reset
// or the last limit write. The count table sits in a RAM with one write and
// one registered read port. A query steps through Q_CHK, Q_LO and Q_END (a
// flagged one goes from Q_CHK straight to DONE); in DONE its result is loaded
// into the output register once that register is free, and the next request
// is then taken in IDLE. A build clears the table over 0..L, then for each
// number in 2..L reads and classifies it, marks each multiple through IN_RD,
// IN_MUL and IN_CHK, ends the marking in IN_CHK (in IN_RD when the prime list
// runs out) and advances in NEXT_I, and last turns factors into running
// counts. No clearing pass runs after reset, since each build clears the
// table itself. A finished result is held in an output register, so a new
// request is taken while the previous result still waits.
module linear_sieve_prime_counter
    import lspc_pkg::*;
#(
    parameter int TABLE_SIZE       = 131072,
    parameter int PRIME_LIST_DEPTH = 16384
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [16:0]  cfg_wr_data,  // sieve_limit
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,      // low_bound[16:0], high_bound[33:17], zero pad
    input  wire logic [0:0]   s_tuser,      // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [15:0]  m_tdata,      // prime_count[15:0]
    output logic      [1:0]   m_tuser       // status[1:0]
);

    cmd_t  cmd;
    stat_t stat;

    lspc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_mode  (s_tuser[0]),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lspc_datapath #(
        .TABLE_SIZE      (TABLE_SIZE),
        .PRIME_LIST_DEPTH(PRIME_LIST_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_low      (s_tdata[16:0]),
        .s_high     (s_tdata[33:17]),
        .cmd        (cmd),
        .stat       (stat),
        .m_count    (m_tdata),
        .m_status   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the linear sieve prime counter.
// Depends on lspc_pkg and on linear_sieve_prime_counter; holds its own sieve
// predictor, a directed stimulus table and randomised phases of build and query requests.
`timescale 1ns / 100ps

module testbench
    import lspc_pkg::*;
();

    localparam int TABLE_SIZE       = 131072;
    localparam int PRIME_LIST_DEPTH = 16384;
    localparam int ITEM_TARGET      = 1600;
    localparam int CALM_TAIL        = 150;
    localparam int SETTLE_CYCLES    = 8;
    localparam int REPORT_LIMIT     = 10;

    localparam logic MODE_BUILD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_MIN = 17'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 17'd131071;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } prime_reply_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               mode;
        logic [LIMIT_W-1:0] lo;     // also the limit value of a register write
        logic [LIMIT_W-1:0] hi;
        logic               has_reply;
        prime_reply_t       reply;
    } stim_row_t;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [16:0]        cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata     = '0;   // low_bound[16:0], high_bound[33:17], zero pad
    logic [0:0]         s_tuser     = '0;   // mode
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [15:0]        m_tdata;            // prime_count[15:0]
    logic [1:0]         m_tuser;            // status[1:0]

    linear_sieve_prime_counter #(
        .TABLE_SIZE      (TABLE_SIZE),
        .PRIME_LIST_DEPTH(PRIME_LIST_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Predictor state, mirroring the block after reset.
    logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;
    logic [FOUND_W-1:0] model_found = '0;
    bit                 model_built = 1'b0;
    int                 count_table [TABLE_SIZE];
    int                 sieve_primes [PRIME_LIST_DEPTH];

    prime_reply_t awaited_replies[$];
    stim_row_t    directed_rows[$];

    int  mismatches      = 0;
    int  replies_checked = 0;
    int  requests_sent   = 0;
    int  builds_sent     = 0;
    int  queries_sent    = 0;
    int  limits_written  = 0;
    bit  idle_enable     = 1'b1;
    bit  no_idle         = 1'b0;
    int  stall_left      = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $display("Run timed out with %0d replies outstanding.", awaited_replies.size());
        $finish;
    end

    function automatic int effective_limit();
        int lim;
        lim = model_limit;
        if (lim > TABLE_SIZE - 1)
            lim = TABLE_SIZE - 1;
        return lim;
    endfunction

    // Linear sieve into the factor table, then an in-place pass that turns
    // the factors into running prime counts.
    function automatic void build_count_table();
        int     lim;
        int     listed;
        int     total;
        int     run;
        int     fi;
        int     p;
        longint prod;
        lim    = effective_limit();
        listed = 0;
        total  = 0;
        for (int k = 0; k < TABLE_SIZE; k++)
            count_table[k] = 0;
        for (int i = 2; i <= lim; i++) begin
            if (count_table[i] == 0) begin
                count_table[i] = i;
                total++;
                if (listed < PRIME_LIST_DEPTH) begin
                    sieve_primes[listed] = i;
                    listed++;
                end
            end
            fi = count_table[i];
            for (int j = 0; j < listed; j++) begin
                p    = sieve_primes[j];
                prod = longint'(i) * longint'(p);
                if (p > fi || prod > lim)
                    break;
                count_table[int'(prod)] = p;
            end
        end
        run = 0;
        for (int i = 0; i <= lim; i++) begin
            if (i >= 2 && count_table[i] == i)
                run++;
            count_table[i] = run & 'h1FFFF;
        end
        model_found = total[FOUND_W-1:0];
        model_built = 1'b1;
    endfunction

    function automatic prime_reply_t predict_reply(logic mode, logic [LIMIT_W-1:0] lo,
                                                   logic [LIMIT_W-1:0] hi);
        prime_reply_t r;
        int           lim;
        int           upper;
        int           lower;
        int           diff;
        r.count  = '0;
        r.status = STAT_OK;
        if (mode == MODE_BUILD) begin
            build_count_table();
            r.count = {1'b0, model_found};
        end else if (!model_built) begin
            r.status = STAT_UNBUILT;
        end else begin
            lim = effective_limit();
            if (int'(lo) > lim || int'(hi) > lim) begin
                r.status = STAT_RANGE;
            end else begin
                upper   = count_table[hi];
                lower   = (lo == 0) ? 0 : count_table[lo - 1];
                diff    = upper - lower;
                r.count = diff[COUNT_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void add_row(row_kind_t kind, logic mode, logic [LIMIT_W-1:0] lo,
                                    logic [LIMIT_W-1:0] hi, logic has_reply,
                                    logic [COUNT_W-1:0] count, logic [STATUS_W-1:0] status);
        stim_row_t row;
        row.kind         = kind;
        row.mode         = mode;
        row.lo           = lo;
        row.hi           = hi;
        row.has_reply    = has_reply;
        row.reply.count  = count;
        row.reply.status = status;
        directed_rows.push_back(row);
    endfunction

    // Presents one request, waits for its handshake and files the reply it
    // should cause; a typed reply replaces the predicted one in the queue.
    task automatic send_request(logic mode, logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] hi,
                                logic has_reply, prime_reply_t fixed_reply);
        prime_reply_t predicted;
        int           gap;
        if (idle_enable && !no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, hi, lo};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_reply(mode, lo, hi);
        awaited_replies.push_back(has_reply ? fixed_reply : predicted);
        requests_sent++;
        if (mode == MODE_BUILD)
            builds_sent++;
        else
            queries_sent++;
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_limit = value;
        model_built = 1'b0;
        limits_written++;
    endtask

    // Result side: random stall bursts while idling is allowed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (idle_enable && !no_idle && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 19);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        prime_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_replies.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: reply with nothing awaited: count %0d status %0d",
                             $realtime, $signed(m_tdata), m_tuser);
                mismatches++;
            end else begin
                want = awaited_replies.pop_front();
                replies_checked++;
                if (m_tdata !== want.count || m_tuser !== want.status) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: reply %0d: count %0d/%0d status %0d/%0d (exp/got)",
                                 $realtime, replies_checked, $signed(want.count),
                                 $signed(m_tdata), want.status, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        stim_row_t          row;
        prime_reply_t       no_reply;
        logic [LIMIT_W-1:0] lim;
        logic [LIMIT_W-1:0] lo;
        logic [LIMIT_W-1:0] hi;
        int                 pick;
        int                 phase;
        int                 items;
        int                 pause_at;
        int                 unbuilt_n;
        no_reply = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Queries before any build, a small sieve with its edge cases, the
        // smallest limit and one sieve over the whole table.
        add_row(ROW_REQ, MODE_QUERY, 17'd1, 17'd10, 1'b1, 16'd0, STAT_UNBUILT);
        add_row(ROW_REQ, MODE_QUERY, LIMIT_MAX, 17'd0, 1'b1, 16'd0, STAT_UNBUILT);
        add_row(ROW_CFG, MODE_QUERY, 17'd30, 17'd0, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd1, 17'd30, 1'b1, 16'd0, STAT_UNBUILT);
        add_row(ROW_REQ, MODE_BUILD, LIMIT_MAX, LIMIT_MAX, 1'b1, 16'd10, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd1, 17'd30, 1'b1, 16'd10, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd0, 17'd30, 1'b1, 16'd10, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd0, 17'd0, 1'b1, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd31, 17'd5, 1'b1, 16'd0, STAT_RANGE);
        add_row(ROW_REQ, MODE_QUERY, 17'd5, 17'd31, 1'b1, 16'd0, STAT_RANGE);
        add_row(ROW_REQ, MODE_QUERY, LIMIT_MAX, LIMIT_MAX, 1'b1, 16'd0, STAT_RANGE);
        add_row(ROW_REQ, MODE_QUERY, 17'd20, 17'd10, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd11, 17'd10, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd2, 17'd2, 1'b1, 16'd1, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd29, 17'd29, 1'b1, 16'd1, STAT_OK);
        add_row(ROW_CFG, MODE_QUERY, LIMIT_MIN, 17'd0, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_BUILD, 17'h15555, 17'h0AAAA, 1'b1, 16'd1, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd0, 17'd2, 1'b1, 16'd1, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd3, 17'd3, 1'b1, 16'd0, STAT_RANGE);
        add_row(ROW_REQ, MODE_QUERY, 17'd1, 17'd1, 1'b1, 16'd0, STAT_OK);
        add_row(ROW_CFG, MODE_QUERY, LIMIT_MAX, 17'd0, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd0, LIMIT_MAX, 1'b1, 16'd0, STAT_UNBUILT);
        add_row(ROW_REQ, MODE_BUILD, 17'd0, 17'd0, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd0, LIMIT_MAX, 1'b0, 16'd0, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, LIMIT_MAX, LIMIT_MAX, 1'b1, 16'd1, STAT_OK);
        add_row(ROW_REQ, MODE_QUERY, 17'd1, LIMIT_MAX - 17'd1, 1'b0, 16'd0, STAT_OK);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                drain_replies();
                write_limit(row.lo);
            end else begin
                send_request(row.mode, row.lo, row.hi, row.has_reply, row.reply);
            end
        end

        // Random phases: a limit write, a few requests that must find the table
        // unbuilt, a build, then mostly well-formed queries with some noise.
        phase = 0;
        while (requests_sent < ITEM_TARGET) begin
            drain_replies();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                lim = LIMIT_W'($urandom_range(2, 12));
            else if (pick == 1)
                lim = LIMIT_W'($urandom_range(3000, 6000));
            else
                lim = LIMIT_W'($urandom_range(13, 1500));
            write_limit(lim);
            idle_enable <= ($urandom_range(0, 3) != 0);
            items    = $urandom_range(60, 140);
            pause_at = (phase == 0 || $urandom_range(0, 1) == 1) ?
                       $urandom_range(5, items - 5) : -1;

            unbuilt_n = $urandom_range(0, 2);
            for (int k = 0; k < unbuilt_n; k++)
                send_request(MODE_QUERY, LIMIT_W'($urandom_range(0, 131071)),
                             LIMIT_W'($urandom_range(0, 131071)), 1'b0, no_reply);
            send_request(MODE_BUILD, LIMIT_W'($urandom_range(0, 131071)),
                         LIMIT_W'($urandom_range(0, 131071)), 1'b0, no_reply);

            for (int k = 0; k < items && requests_sent < ITEM_TARGET; k++) begin
                if (!no_idle && requests_sent >= ITEM_TARGET - CALM_TAIL)
                    no_idle <= 1'b1;
                // Hold the sender back until the block has answered everything.
                if (k == pause_at)
                    drain_replies();
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    lo = LIMIT_W'($urandom_range(0, lim));
                    hi = LIMIT_W'($urandom_range(lo, lim));
                end else if (pick < 76) begin
                    lo = '0;
                    hi = LIMIT_W'($urandom_range(0, lim));
                end else if (pick < 80) begin
                    lo = LIMIT_W'($urandom_range(0, lim));
                    hi = lim;
                end else if (pick < 86) begin
                    lo = LIMIT_W'($urandom_range(1, lim));
                    hi = LIMIT_W'($urandom_range(0, lo - 1));
                end else if (pick < 90) begin
                    lo = LIMIT_W'($urandom_range(0, lim));
                    hi = lim + 17'd1;
                    if ($urandom_range(0, 1) == 1) begin
                        hi = lo;
                        lo = lim + 17'd1;
                    end
                end else if (pick < 97) begin
                    lo = LIMIT_W'($urandom_range(0, 131071));
                    hi = LIMIT_W'($urandom_range(0, 131071));
                end
                if (pick < 97)
                    send_request(MODE_QUERY, lo, hi, 1'b0, no_reply);
                else
                    send_request(MODE_BUILD, LIMIT_W'($urandom_range(0, 131071)),
                                 LIMIT_W'($urandom_range(0, 131071)), 1'b0, no_reply);
            end
            phase++;
        end

        drain_replies();
        $display("Sent %0d requests (%0d builds, %0d queries), %0d replies checked.",
                 requests_sent, builds_sent, queries_sent, replies_checked);
        $display("Sieve limit written %0d times, from 2 up to the full table; %0d mismatches.",
                 limits_written, mismatches);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lspc_pkg.sv
rtl/lspc_ram.sv
rtl/lspc_datapath.sv
rtl/lspc_ctrl.sv
rtl/linear_sieve_prime_counter.sv
tb/testbench.sv
